[design/codp_pkg.sv]
// Shared types and constants of the clock output divider programmer.
package codp_pkg;

  localparam int NUM_OUTPUTS_DEF = 6;
  localparam int FREQ_W = 33;
  localparam int DEN_W = 20;
  localparam int MSF_W = 40;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [35:0] PLL_KHZ_Q16 = 36'd49152000000;
  localparam logic [FREQ_W-1:0] MIN_OUT_RST = 33'd262144;
  localparam logic [FREQ_W-1:0] MAX_OUT_RST = 33'd7340032000;
  localparam logic [FREQ_W-1:0] MIN_MS_RST = 33'd32768000;
  localparam logic [DEN_W-1:0] DEN_RST = 20'd1048575;
  localparam logic [7:0] MASK_RST = 8'hFF;

  typedef enum logic [1:0] {
    CFG_MIN_OUT = 2'd0,
    CFG_MAX_OUT = 2'd1,
    CFG_MIN_MS = 2'd2,
    CFG_DEN = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [2:0] idx;
    logic [FREQ_W-1:0] freq;
    logic [7:0] phase;
    logic ok;
    logic [2:0] rcode;
  } item_t;

endpackage

[design/codp_front.sv]
// Front end: configuration registers, request intake and classification.
module codp_front
  import codp_pkg::*;
#(
  parameter int NUM_OUTPUTS = NUM_OUTPUTS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  logic [2:0] output_index,
  input  logic [FREQ_W-1:0] freq_khz_q16,
  input  logic [7:0] phase_byte,
  input  logic cfg_valid,
  input  logic [1:0] cfg_index,
  input  logic [FREQ_W-1:0] cfg_data,
  input  logic q_full,
  output logic q_push,
  output item_t q_item,
  output logic [DEN_W-1:0] den
);

  logic [FREQ_W-1:0] min_out;
  logic [FREQ_W-1:0] max_out;
  logic [FREQ_W-1:0] min_ms;
  logic [7:0] found;
  logic in_range;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_out <= MIN_OUT_RST;
      max_out <= MAX_OUT_RST;
      min_ms <= MIN_MS_RST;
      den <= DEN_RST;
    end else if (cfg_valid) begin
      case (cfg_idx_t'(cfg_index))
        CFG_MIN_OUT: min_out <= cfg_data;
        CFG_MAX_OUT: max_out <= cfg_data;
        CFG_MIN_MS: min_ms <= cfg_data;
        CFG_DEN: den <= cfg_data[DEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int k = 0; k < 8; k++) begin
      found[k] = (({7'd0, freq_khz_q16} << k) > {7'd0, min_ms});
    end
    in_range = (freq_khz_q16 >= min_out) && (freq_khz_q16 <= max_out);
    q_item.idx = output_index;
    q_item.freq = freq_khz_q16;
    q_item.phase = phase_byte;
    q_item.rcode = 3'd0;
    for (int k = 7; k >= 0; k--) begin
      if (found[k]) begin
        q_item.rcode = 3'(k);
      end
    end
    q_item.ok = in_range && (found != 8'd0);
  end

  assign q_push = push && !q_full && ({29'd0, output_index} < NUM_OUTPUTS);

endmodule

[design/codp_queue.sv]
// Short queue of classified requests between front and back.
module codp_queue
  import codp_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic wr_en,
  input  item_t wr_item,
  input  logic rd_en,
  output item_t rd_item,
  output logic q_full,
  output logic q_empty
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  item_t slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0] count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (wr_en && !rd_en) begin
        count <= count + 1'b1;
      end else if (rd_en && !wr_en) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wr_ptr] <= wr_item;
    end
  end

  assign rd_item = slots[rd_ptr];
  assign q_full = (count == (PTR_W + 1)'(QUEUE_DEPTH));
  assign q_empty = (count == '0);

endmodule

[design/codp_back.sv]
// Back end: shared serial divider, P1/P2 encoding and register write sequencer.
module codp_back
  import codp_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic q_empty,
  input  item_t q_item,
  input  logic [DEN_W-1:0] den,
  input  logic pop,
  output logic q_pop,
  output logic empty,
  output logic [7:0] reg_addr,
  output logic [7:0] reg_data,
  output logic last_write,
  output logic accepted
);

  typedef enum logic [2:0] {
    S_IDLE, S_DIV1, S_MUL, S_DIV2, S_DIV3, S_CALC, S_EMIT
  } state_t;

  typedef enum logic [3:0] {
    W_P3_HI, W_P3_LO, W_P1_HI, W_P1_MID, W_P1_LO, W_P2_HI, W_P2_MID, W_P2_LO,
    W_PHASE, W_CC_CTRL, W_CC_EN, W_CC_MASK
  } slot_t;

  state_t state;
  slot_t slot;
  item_t it;
  logic [5:0] cnt;
  logic [MSF_W-1:0] rem;
  logic [MSF_W-1:0] dsr;
  logic [63:0] num;
  logic [35:0] quo;
  logic [59:0] prod;
  logic [10:0] ip_lo;
  logic [19:0] numer;
  logic [6:0] f;
  logic [17:0] p1;
  logic [19:0] p2;
  logic [7:0] mask;
  logic out_valid;

  logic [41:0] trial;
  logic ge;
  logic [MSF_W-1:0] rem_next;
  logic [26:0] fden;
  logic [7:0] base;
  logic [7:0] mask_next;
  logic [7:0] w_addr;
  logic [7:0] w_data;
  logic take;

  always_comb begin
    trial = {1'b0, rem, num[63]} - {2'b00, dsr};
    ge = !trial[41];
    rem_next = ge ? trial[MSF_W-1:0] : {rem[MSF_W-2:0], num[63]};
    fden = den * f;
    base = 8'd42 + {2'b00, it.idx, 3'b000};
    mask_next = (mask & ~(8'd1 << it.idx)) | ({7'd0, !it.ok} << it.idx);
    w_addr = 8'd3;
    w_data = mask_next;
    case (slot)
      W_P3_HI: begin w_addr = base; w_data = den[15:8]; end
      W_P3_LO: begin w_addr = base + 8'd1; w_data = den[7:0]; end
      W_P1_HI: begin w_addr = base + 8'd2; w_data = {1'b0, it.rcode, 2'b00, p1[17:16]}; end
      W_P1_MID: begin w_addr = base + 8'd3; w_data = p1[15:8]; end
      W_P1_LO: begin w_addr = base + 8'd4; w_data = p1[7:0]; end
      W_P2_HI: begin w_addr = base + 8'd5; w_data = {den[19:16], p2[19:16]}; end
      W_P2_MID: begin w_addr = base + 8'd6; w_data = p2[15:8]; end
      W_P2_LO: begin w_addr = base + 8'd7; w_data = p2[7:0]; end
      W_PHASE: begin w_addr = 8'd165 + {5'd0, it.idx}; w_data = it.phase; end
      W_CC_CTRL: begin w_addr = 8'd16 + {5'd0, it.idx}; w_data = {!it.ok, 7'h0F}; end
      W_CC_EN: begin w_addr = (it.idx > 3'd3) ? 8'd25 : 8'd24; w_data = 8'h00; end
      W_CC_MASK: begin w_addr = 8'd3; w_data = mask_next; end
      default: ;
    endcase
  end

  assign take = (state == S_EMIT) && (!out_valid || pop);
  assign q_pop = (state == S_IDLE) && !q_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      slot <= W_P3_HI;
      cnt <= '0;
      mask <= MASK_RST;
      out_valid <= 1'b0;
    end else begin
      if (pop && out_valid) begin
        out_valid <= 1'b0;
      end
      if (state == S_DIV1 || state == S_DIV2 || state == S_DIV3) begin
        rem <= rem_next;
        num <= {num[62:0], 1'b0};
        quo <= {quo[34:0], ge};
        cnt <= cnt - 1'b1;
      end
      case (state)
        S_IDLE: begin
          if (!q_empty) begin
            it <= q_item;
            if (q_item.ok) begin
              state <= S_DIV1;
              dsr <= {7'd0, q_item.freq} << q_item.rcode;
              num <= {PLL_KHZ_Q16, 28'd0};
              rem <= '0;
              cnt <= 6'd36;
              slot <= W_P3_HI;
            end else begin
              state <= S_EMIT;
              slot <= W_CC_CTRL;
            end
          end
        end
        S_DIV1: begin
          if (cnt == 6'd1) begin
            state <= S_MUL;
          end
        end
        S_MUL: begin
          ip_lo <= quo[10:0];
          prod <= rem * den;
          state <= S_DIV2;
          cnt <= 6'd61;
        end
        S_DIV2: begin
          if (cnt == 6'd61) begin
            num <= {prod, 4'd0};
            rem <= '0;
            cnt <= 6'd60;
          end else if (cnt == 6'd0) begin
            numer <= quo[19:0];
            num <= {quo[19:0], 44'd0};
            dsr <= {20'd0, den};
            rem <= '0;
            cnt <= 6'd27;
            state <= S_DIV3;
          end
        end
        S_DIV3: begin
          if (cnt == 6'd1) begin
            state <= S_CALC;
          end
        end
        S_CALC: begin
          f <= (den == '0) ? 7'd0 : quo[6:0];
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (slot == W_P3_HI) begin
            p1 <= {ip_lo, 7'd0} + {11'd0, f} - 18'd512;
            p2 <= {numer[12:0], 7'd0} - fden[19:0];
          end
          if (take) begin
            out_valid <= 1'b1;
            reg_addr <= w_addr;
            reg_data <= w_data;
            accepted <= it.ok;
            last_write <= (slot == W_CC_MASK);
            if (slot == W_CC_MASK) begin
              mask <= mask_next;
              state <= S_IDLE;
            end else begin
              slot <= slot_t'(slot + 1'b1);
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign empty = !out_valid;

endmodule

[design/clock_output_divider_programmer.sv]
// Top level of the clock output divider programmer.
// A request runs through a two-entry queue into a back end whose single bit-serial
// divider does three divisions (36, 60 and 27 steps) before an accepted request's
// twelve writes, while a rejected one goes straight to its three writes; writes
// leave through one output register at most one per cycle as pop allows, and
// requests for an output past the last are dropped.
module clock_output_divider_programmer
  import codp_pkg::*;
#(
  parameter int NUM_OUTPUTS = NUM_OUTPUTS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  output logic full,
  input  logic [2:0] output_index,
  input  logic [FREQ_W-1:0] freq_khz_q16,
  input  logic [7:0] phase_byte,
  output logic empty,
  input  logic pop,
  output logic [7:0] reg_addr,
  output logic [7:0] reg_data,
  output logic last_write,
  output logic accepted,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [FREQ_W-1:0] cfg_data
);

  logic q_push;
  logic q_pop;
  logic q_empty;
  item_t q_in;
  item_t q_out;
  logic [DEN_W-1:0] den;

  assign cfg_ready = 1'b1;

  codp_front #(.NUM_OUTPUTS(NUM_OUTPUTS)) u_front (
    .clk, .rst, .push, .output_index, .freq_khz_q16, .phase_byte,
    .cfg_valid, .cfg_index, .cfg_data,
    .q_full(full), .q_push, .q_item(q_in), .den
  );

  codp_queue u_queue (
    .clk, .rst, .wr_en(q_push), .wr_item(q_in), .rd_en(q_pop),
    .rd_item(q_out), .q_full(full), .q_empty
  );

  codp_back u_back (
    .clk, .rst, .q_empty, .q_item(q_out), .den, .pop, .q_pop,
    .empty, .reg_addr, .reg_data, .last_write, .accepted
  );

endmodule

[design/codp_checker.sv]
// Port-level checks of the clock output divider programmer, bound to the top level.
module codp_checker (
  input logic clk,
  input logic rst,
  input logic empty,
  input logic pop,
  input logic [7:0] reg_addr,
  input logic last_write,
  input logic accepted
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty && $stable(reg_addr))
    else $error("waiting write changed before its transfer");

  a_reset: assert property (@(posedge clk) rst |=> empty)
    else $error("write shown right after reset");

  a_last: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (last_write == (reg_addr == 8'd3)))
    else $error("final write is not the disable mask write");

  a_phase: assert property (@(posedge clk) disable iff (rst)
    !empty && reg_addr >= 8'd165 |-> accepted)
    else $error("phase write for a rejected request");

endmodule

bind clock_output_divider_programmer codp_checker u_chk (.*);
